// ----- rtl/llpe_pkg.sv -----
// llpe_pkg: operation and status codes for the linked-list pool engine
// no dependencies; imported by the engine core
`timescale 1ns / 1ps
package llpe_pkg;

  typedef logic [3:0] op_t;
  typedef logic [2:0] status_t;

  localparam op_t OP_CREATE  = 4'd0;
  localparam op_t OP_DESTROY = 4'd1;
  localparam op_t OP_CLEAR   = 4'd2;
  localparam op_t OP_EMPTY   = 4'd3;
  localparam op_t OP_LENGTH  = 4'd4;
  localparam op_t OP_GET     = 4'd5;
  localparam op_t OP_LOCATE  = 4'd6;
  localparam op_t OP_NEXT    = 4'd7;
  localparam op_t OP_PRIOR   = 4'd8;
  localparam op_t OP_INSERT  = 4'd9;
  localparam op_t OP_DELETE  = 4'd10;

  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_NO_FREE  = 3'd1;
  localparam status_t ST_NOT_FND  = 3'd2;
  localparam status_t ST_BAD_POS  = 3'd3;
  localparam status_t ST_BAD_HEAD = 3'd4;

  localparam logic [7:0] NONE_OUT = 8'hFF;

endpackage

// ----- rtl/llpe_ram.sv -----
// llpe_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies; used for the link and data stores
`timescale 1ns / 1ps
module llpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/linked_list_pool_engine_core.sv -----
// linked_list_pool_engine_core: node pool with free list and list operations
// depends on llpe_pkg and llpe_ram (link store and data store)
// steps: read the head node, follow links one by one, write back where needed;
//   clear follows at most NODES+1 links, get and insert up to position (at most 255)
// throughput: one request at a time; a new beat is taken while the last result waits
// reset: synchronous; after reset a pass writes the link store
//   (entry i links to i+1, last none) and no request beat is taken until it ends
`timescale 1ns / 1ps
module linked_list_pool_engine_core #(
  parameter int NODES      = 128,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  llpe_pkg::op_t         op,
  input  logic [7:0]            head,
  input  logic [7:0]            position,
  input  logic signed [31:0]    value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output llpe_pkg::status_t     status,
  output logic [7:0]            node_index,
  output logic signed [31:0]    element,
  output logic [7:0]            element_count,
  output logic                  is_empty
);

  import llpe_pkg::*;

  // node index width; links carry an extra none flag at the top
  localparam int AW = $clog2(NODES);
  localparam int LW = AW + 1;
  // step counter must reach NODES+1 and any position value
  localparam int CW = ($clog2(NODES + 2) > 8) ? $clog2(NODES + 2) : 8;
  localparam logic [LW-1:0] NIL = {1'b1, {AW{1'b0}}};

  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_WALK = 4'd2;
  localparam logic [3:0] S_CRT  = 4'd3;
  localparam logic [3:0] S_INS1 = 4'd4;
  localparam logic [3:0] S_INS2 = 4'd5;
  localparam logic [3:0] S_DEL2 = 4'd6;
  localparam logic [3:0] S_CLR2 = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0]            state, state_next;
  logic [AW-1:0]         init_cnt;
  op_t                   op_r, op_r_next;
  logic [AW-1:0]         head_r, head_r_next;
  logic [7:0]            pos_r, pos_r_next;
  logic [DATA_WIDTH-1:0] v_r, v_r_next;
  logic [AW-1:0]         cur, cur_next;
  logic [AW-1:0]         prev, prev_next;
  logic [CW-1:0]         cnt, cnt_next;
  logic [AW-1:0]         first, first_next;
  logic [AW-1:0]         pn, pn_next;
  logic [LW-1:0]         plink, plink_next;
  logic [LW-1:0]         free_head, free_head_next;

  status_t               res_status, res_status_next;
  logic [7:0]            res_idx, res_idx_next;
  logic [31:0]           res_elem, res_elem_next;
  logic [7:0]            res_count, res_count_next;
  logic                  res_empty, res_empty_next;

  // memory ports
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [LW-1:0]         rd_link;
  logic [DATA_WIDTH-1:0] rd_val;
  logic                  link_we;
  logic [AW-1:0]         link_waddr;
  logic [LW-1:0]         link_wdata;
  logic                  val_we;

  logic [12:0]           head_ext;
  logic                  head_ok;
  logic                  lnil;
  logic [AW-1:0]         lidx;
  logic [12:0]           cnt_ext;
  logic                  load_out;

  llpe_ram #(.WIDTH(LW), .DEPTH(NODES)) u_links (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_link)
  );

  llpe_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NODES)) u_values (
    .clk   (clk),
    .we    (val_we),
    .waddr (link_waddr),
    .wdata (v_r),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_val)
  );

  assign in_ready = (state == S_IDLE);
  assign head_ext = 13'(head);
  assign head_ok  = head_ext < 13'(NODES);
  assign lnil     = rd_link[AW];
  assign lidx     = rd_link[AW-1:0];
  assign cnt_ext  = 13'(cnt);
  assign load_out = (state == S_FIN) && (!out_valid || out_ready);

  always_comb begin
    state_next      = state;
    op_r_next       = op_r;
    head_r_next     = head_r;
    pos_r_next      = pos_r;
    v_r_next        = v_r;
    cur_next        = cur;
    prev_next       = prev;
    cnt_next        = cnt;
    first_next      = first;
    pn_next         = pn;
    plink_next      = plink;
    free_head_next  = free_head;
    res_status_next = res_status;
    res_idx_next    = res_idx;
    res_elem_next   = res_elem;
    res_count_next  = res_count;
    res_empty_next  = res_empty;
    rd_en           = 1'b0;
    rd_addr         = cur;
    link_we         = 1'b0;
    link_waddr      = cur;
    link_wdata      = NIL;
    val_we          = 1'b0;

    unique case (state)
      S_INIT: begin
        // reset pass: chain every node onto the free list
        link_we    = 1'b1;
        link_waddr = init_cnt;
        if (init_cnt == AW'(NODES - 1)) begin
          link_wdata = NIL;
          state_next = S_IDLE;
        end else begin
          link_wdata = {1'b0, init_cnt + AW'(1)};
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          op_r_next       = op;
          head_r_next     = head_ext[AW-1:0];
          pos_r_next      = position;
          v_r_next        = DATA_WIDTH'(value);
          res_status_next = ST_OK;
          res_idx_next    = NONE_OUT;
          res_elem_next   = '0;
          res_count_next  = '0;
          res_empty_next  = 1'b0;
          cur_next        = head_ext[AW-1:0];
          prev_next       = head_ext[AW-1:0];
          cnt_next        = '0;
          if (op == OP_CREATE) begin
            if (free_head[AW]) begin
              res_status_next = ST_NO_FREE;
              state_next      = S_FIN;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = free_head[AW-1:0];
              first_next = free_head[AW-1:0];
              state_next = S_CRT;
            end
          end else if (op > OP_DELETE) begin
            state_next = S_FIN;
          end else if (!head_ok) begin
            res_status_next = ST_BAD_HEAD;
            state_next      = S_FIN;
          end else if ((op == OP_GET || op == OP_INSERT) && position == 8'd0) begin
            res_status_next = ST_BAD_POS;
            state_next      = S_FIN;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = head_ext[AW-1:0];
            state_next = S_WALK;
          end
        end
      end

      S_WALK: begin
        // rd_link and rd_val hold node cur, reached after cnt links
        case (op_r)
          OP_DESTROY: begin
            if (lnil) begin
              link_we        = 1'b1;
              link_waddr     = cur;
              link_wdata     = free_head;
              free_head_next = {1'b0, head_r};
              state_next     = S_FIN;
            end else if (cnt_ext >= 13'(NODES)) begin
              res_status_next = ST_NOT_FND;
              state_next      = S_FIN;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = lidx;
              cur_next  = lidx;
              prev_next = cur;
              cnt_next  = cnt + CW'(1);
            end
          end

          OP_CLEAR: begin
            if (cnt == '0) begin
              if (lnil) begin
                state_next = S_FIN;
              end else begin
                first_next = lidx;
                rd_en      = 1'b1;
                rd_addr    = lidx;
                cur_next   = lidx;
                prev_next  = cur;
                cnt_next   = cnt + CW'(1);
              end
            end else if (lnil) begin
              link_we        = 1'b1;
              link_waddr     = cur;
              link_wdata     = free_head;
              free_head_next = {1'b0, first};
              state_next     = S_CLR2;
            end else if (cnt_ext >= 13'(NODES + 1)) begin
              res_status_next = ST_NOT_FND;
              state_next      = S_FIN;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = lidx;
              cur_next  = lidx;
              prev_next = cur;
              cnt_next  = cnt + CW'(1);
            end
          end

          OP_EMPTY: begin
            res_empty_next = lnil;
            state_next     = S_FIN;
          end

          OP_LENGTH: begin
            if (lnil || cnt_ext == 13'(NODES)) begin
              res_count_next = 8'(cnt);
              state_next     = S_FIN;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = lidx;
              cur_next  = lidx;
              prev_next = cur;
              cnt_next  = cnt + CW'(1);
            end
          end

          OP_GET: begin
            if (cnt_ext == 13'(pos_r)) begin
              res_idx_next  = 8'(cur);
              res_elem_next = 32'(rd_val);
              state_next    = S_FIN;
            end else if (lnil) begin
              res_status_next = ST_BAD_POS;
              state_next      = S_FIN;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = lidx;
              cur_next  = lidx;
              prev_next = cur;
              cnt_next  = cnt + CW'(1);
            end
          end

          OP_INSERT: begin
            if (cnt_ext + 13'd1 == 13'(pos_r)) begin
              pn_next    = cur;
              plink_next = rd_link;
              if (free_head[AW]) begin
                res_status_next = ST_NO_FREE;
                state_next      = S_FIN;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = free_head[AW-1:0];
                first_next = free_head[AW-1:0];
                state_next = S_INS1;
              end
            end else if (lnil) begin
              res_status_next = ST_BAD_POS;
              state_next      = S_FIN;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = lidx;
              cur_next  = lidx;
              prev_next = cur;
              cnt_next  = cnt + CW'(1);
            end
          end

          default: begin
            // locate, next, prior, delete: search elements after the head
            if (cnt != '0 && rd_val == v_r) begin
              state_next = S_FIN;
              case (op_r)
                OP_LOCATE: res_idx_next = 8'(cur);
                OP_NEXT: begin
                  if (lnil) begin
                    res_status_next = ST_NOT_FND;
                  end else begin
                    res_idx_next = 8'(lidx);
                  end
                end
                OP_PRIOR: begin
                  if (prev == head_r) begin
                    res_status_next = ST_NOT_FND;
                  end else begin
                    res_idx_next = 8'(prev);
                  end
                end
                default: begin
                  // unlink cur from its predecessor, then free it
                  link_we    = 1'b1;
                  link_waddr = prev;
                  link_wdata = rd_link;
                  state_next = S_DEL2;
                end
              endcase
            end else if (cnt_ext == 13'(NODES) || lnil) begin
              res_status_next = ST_NOT_FND;
              state_next      = S_FIN;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = lidx;
              cur_next  = lidx;
              prev_next = cur;
              cnt_next  = cnt + CW'(1);
            end
          end
        endcase
      end

      S_CRT: begin
        free_head_next = rd_link;
        link_we        = 1'b1;
        link_waddr     = first;
        link_wdata     = NIL;
        res_idx_next   = 8'(first);
        state_next     = S_FIN;
      end

      S_INS1: begin
        // new node takes the old link of the insert point and the value
        free_head_next = rd_link;
        link_we        = 1'b1;
        link_waddr     = first;
        link_wdata     = plink;
        val_we         = 1'b1;
        state_next     = S_INS2;
      end

      S_INS2: begin
        link_we      = 1'b1;
        link_waddr   = pn;
        link_wdata   = {1'b0, first};
        res_idx_next = 8'(first);
        state_next   = S_FIN;
      end

      S_DEL2: begin
        link_we        = 1'b1;
        link_waddr     = cur;
        link_wdata     = free_head;
        free_head_next = {1'b0, cur};
        res_idx_next   = 8'(cur);
        state_next     = S_FIN;
      end

      S_CLR2: begin
        link_we    = 1'b1;
        link_waddr = head_r;
        link_wdata = NIL;
        state_next = S_FIN;
      end

      S_FIN: begin
        // hold the result until the output register is free
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      init_cnt  <= '0;
      free_head <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      free_head <= free_head_next;
      if (state == S_INIT) begin
        init_cnt <= init_cnt + AW'(1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r       <= op_r_next;
    head_r     <= head_r_next;
    pos_r      <= pos_r_next;
    v_r        <= v_r_next;
    cur        <= cur_next;
    prev       <= prev_next;
    cnt        <= cnt_next;
    first      <= first_next;
    pn         <= pn_next;
    plink      <= plink_next;
    res_status <= res_status_next;
    res_idx    <= res_idx_next;
    res_elem   <= res_elem_next;
    res_count  <= res_count_next;
    res_empty  <= res_empty_next;
    if (load_out) begin
      status        <= res_status;
      node_index    <= res_idx;
      element       <= res_elem;
      element_count <= res_count;
      is_empty      <= res_empty;
    end
  end

endmodule

// ----- tb/tb.sv -----
// tb: self-checking bench for linked_list_pool_engine_core, directed and random requests
// depends on llpe_pkg and the engine core rtl; keeps its own model of the node pool
`timescale 1ns / 1ps
module tb;
  import llpe_pkg::*;

  localparam int NODES = 128;
  localparam int NIL = 'hFFFF;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    status_t     st;
    logic [7:0]  idx;
    logic [31:0] elem;
    logic [7:0]  cnt;
    logic        emp;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  op_t op = OP_EMPTY;
  logic [7:0] head = 8'd0;
  logic [7:0] position = 8'd0;
  logic signed [31:0] value = 32'sd0;
  logic out_valid;
  logic out_ready = 1'b0;
  status_t status;
  logic [7:0] node_index;
  logic signed [31:0] element;
  logic [7:0] element_count;
  logic is_empty;

  // shadow of the node pool
  int link_mem [NODES];
  logic [31:0] data_mem [NODES];
  bit written [NODES];
  int free_ptr;
  bit unwritten_hit;

  answer_t answer_q[$];
  int live_heads[$];
  int errors = 0;
  int cycles = 0;
  bit calm = 1'b0;
  bit send_gaps = 1'b1;
  int stall_left = 0;

  always #5 clk = ~clk;

  linked_list_pool_engine_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .head(head), .position(position), .value(value),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .node_index(node_index), .element(element),
    .element_count(element_count), .is_empty(is_empty)
  );

  function automatic int link_of(int n);
    if (n < 0 || n >= NODES) return NIL;
    return (link_mem[n] < NODES) ? link_mem[n] : NIL;
  endfunction

  // data read; flags nodes whose data was never written
  function automatic logic [31:0] data_of(int n);
    if (!written[n]) unwritten_hit = 1'b1;
    return data_mem[n];
  endfunction

  // last node of the chain from n; 0 when there is no end within NODES steps
  function automatic bit chain_tail(int n, output int t);
    int steps;
    steps = 0;
    while (link_of(n) != NIL) begin
      if (steps >= NODES) return 1'b0;
      n = link_of(n);
      steps++;
    end
    t = n;
    return 1'b1;
  endfunction

  // predecessor of the first element after hd holding v
  function automatic bit match_pred(int hd, logic [31:0] v, output int pred);
    int p, n, steps;
    p = hd;
    steps = 0;
    while (steps < NODES) begin
      n = link_of(p);
      if (n == NIL) return 1'b0;
      if (data_of(n) == v) begin
        pred = p;
        return 1'b1;
      end
      p = n;
      steps++;
    end
    return 1'b0;
  endfunction

  function automatic int list_len(int hd);
    int p, c;
    p = hd;
    c = 0;
    while (c < NODES && link_of(p) != NIL) begin
      p = link_of(p);
      c++;
    end
    return c;
  endfunction

  // works out the answer to one request and updates the shadow pool
  function automatic answer_t pool_answer(op_t o, int hd, int pos, logic [31:0] v);
    answer_t a;
    int p, n, c, t;
    a = '{st: ST_OK, idx: NONE_OUT, elem: 32'd0, cnt: 8'd0, emp: 1'b0};
    if (o == OP_CREATE) begin
      if (free_ptr == NIL) a.st = ST_NO_FREE;
      else begin
        n = free_ptr;
        free_ptr = link_of(n);
        link_mem[n] = NIL;
        a.idx = n[7:0];
      end
    end else if (o > OP_DELETE) begin
      // unknown codes leave everything alone
    end else if (hd >= NODES) begin
      a.st = ST_BAD_HEAD;
    end else begin
      case (o)
        OP_DESTROY: begin
          if (!chain_tail(hd, t)) a.st = ST_NOT_FND;
          else begin
            link_mem[t] = free_ptr;
            free_ptr = hd;
          end
        end
        OP_CLEAR: begin
          n = link_of(hd);
          if (n != NIL) begin
            if (!chain_tail(n, t)) a.st = ST_NOT_FND;
            else begin
              link_mem[t] = free_ptr;
              free_ptr = n;
              link_mem[hd] = NIL;
            end
          end
        end
        OP_EMPTY: a.emp = (link_of(hd) == NIL);
        OP_LENGTH: a.cnt = 8'(list_len(hd));
        OP_GET: begin
          p = hd;
          c = 0;
          while (c < pos && link_of(p) != NIL) begin
            p = link_of(p);
            c++;
          end
          if (pos == 0 || c < pos) a.st = ST_BAD_POS;
          else begin
            a.idx = p[7:0];
            a.elem = data_of(p);
          end
        end
        OP_LOCATE: begin
          if (!match_pred(hd, v, p)) a.st = ST_NOT_FND;
          else a.idx = 8'(link_of(p));
        end
        OP_NEXT: begin
          if (!match_pred(hd, v, p)) a.st = ST_NOT_FND;
          else begin
            n = link_of(link_of(p));
            if (n == NIL) a.st = ST_NOT_FND;
            else a.idx = n[7:0];
          end
        end
        OP_PRIOR: begin
          if (!match_pred(hd, v, p) || p == hd) a.st = ST_NOT_FND;
          else a.idx = p[7:0];
        end
        OP_INSERT: begin
          if (pos == 0) a.st = ST_BAD_POS;
          else begin
            p = hd;
            c = 0;
            while (c + 1 < pos && link_of(p) != NIL) begin
              p = link_of(p);
              c++;
            end
            if (c + 1 < pos) a.st = ST_BAD_POS;
            else if (free_ptr == NIL) a.st = ST_NO_FREE;
            else begin
              n = free_ptr;
              free_ptr = link_of(n);
              data_mem[n] = v;
              written[n] = 1'b1;
              link_mem[n] = link_of(p);
              link_mem[p] = n;
              a.idx = n[7:0];
            end
          end
        end
        default: begin
          if (!match_pred(hd, v, p)) a.st = ST_NOT_FND;
          else begin
            n = link_of(p);
            link_mem[p] = link_of(n);
            link_mem[n] = free_ptr;
            free_ptr = n;
            a.idx = n[7:0];
          end
        end
      endcase
    end
    return a;
  endfunction

  // sends one request beat; a request that would read never-written data becomes a length query
  task automatic send_req(op_t o, int hd, int pos, logic [31:0] v);
    int saved_links [NODES];
    int saved_free;
    answer_t a;
    saved_links = link_mem;
    saved_free = free_ptr;
    unwritten_hit = 1'b0;
    a = pool_answer(o, hd, pos, v);
    if (unwritten_hit) begin
      link_mem = saved_links;
      free_ptr = saved_free;
      o = OP_LENGTH;
      a = pool_answer(o, hd, pos, v);
    end
    if (o == OP_CREATE && a.st == ST_OK) live_heads.push_back(a.idx);
    answer_q.push_back(a);
    if (send_gaps && !calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    head <= hd[7:0];
    position <= pos[7:0];
    value <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drop_head(int hd);
    foreach (live_heads[i])
      if (live_heads[i] == hd) begin
        live_heads.delete(i);
        return;
      end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
  endtask

  // result checker
  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    answer_t a;
    if (!rst && out_valid && out_ready) begin
      if (answer_q.size() == 0) begin
        $display("result beat with nothing expected");
        errors++;
      end else begin
        a = answer_q.pop_front();
        if (status !== a.st) report("status", 32'(status), 32'(a.st));
        if (node_index !== a.idx) report("node_index", 32'(node_index), 32'(a.idx));
        if (element !== a.elem) report("element", element, a.elem);
        if (element_count !== a.cnt)
          report("element_count", 32'(element_count), 32'(a.cnt));
        if (is_empty !== a.emp) report("is_empty", 32'(is_empty), 32'(a.emp));
      end
    end
  end

  // receiver stalls at random, in bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // edge values, every op, the bad-head, bad-position and not-found statuses
  task automatic test_directed();
    int a;
    send_req(OP_EMPTY, 200, 0, 0);
    send_req(OP_LENGTH, 255, 0, 0);
    send_req(OP_CREATE, 0, 0, 0);
    a = live_heads[$];
    send_req(OP_EMPTY, a, 0, 0);
    send_req(OP_INSERT, a, 0, 5);
    send_req(OP_INSERT, a, 2, 5);
    send_req(OP_INSERT, a, 1, 32'h7fffffff);
    send_req(OP_INSERT, a, 2, 32'h80000000);
    send_req(OP_INSERT, a, 1, 32'h0);
    send_req(OP_INSERT, a, 4, 32'hffffffff);
    send_req(OP_LENGTH, a, 0, 0);
    send_req(OP_GET, a, 0, 0);
    send_req(OP_GET, a, 1, 0);
    send_req(OP_GET, a, 4, 0);
    send_req(OP_GET, a, 5, 0);
    send_req(OP_LOCATE, a, 0, 32'h80000000);
    send_req(OP_LOCATE, a, 0, 32'h12345678);
    send_req(OP_NEXT, a, 0, 32'hffffffff);
    send_req(OP_NEXT, a, 0, 32'h0);
    send_req(OP_PRIOR, a, 0, 32'h0);
    send_req(OP_PRIOR, a, 0, 32'h7fffffff);
    send_req(OP_DELETE, a, 0, 32'h7fffffff);
    send_req(OP_DELETE, a, 0, 32'h7fffffff);
    send_req(op_t'(4'd11), a, 0, 0);
    send_req(op_t'(4'd15), 255, 255, 32'hffffffff);
    send_req(OP_CLEAR, a, 0, 0);
    send_req(OP_CLEAR, a, 0, 0);
    send_req(OP_DESTROY, a, 0, 0);
    drop_head(a);
  endtask

  // run the pool dry, then ask for more nodes
  task automatic test_exhaust();
    int a;
    send_req(OP_CREATE, 0, 0, 0);
    a = live_heads[$];
    while (free_ptr != NIL)
      send_req(OP_INSERT, a, $urandom_range(1, list_len(a) + 1), $urandom_range(0, 15));
    send_req(OP_CREATE, 0, 0, 0);
    send_req(OP_INSERT, a, 1, 7);
    send_req(OP_INSERT, a, 200, 7);
    send_req(OP_DESTROY, a, 0, 0);
    drop_head(a);
  endtask

  // mostly well-formed traffic on live lists, some noise
  task automatic test_random(int count);
    int hd, pos, sel, len;
    logic [31:0] v;
    op_t o;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) wait_drained();
      if (i == count - count / 8) calm = 1'b1;
      v = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 15);
      sel = $urandom_range(0, 99);
      if (live_heads.size() == 0 || sel < 8) begin
        o = OP_CREATE;
        hd = $urandom_range(0, 255);
        pos = 0;
      end else if (sel < 14) begin
        // noise: any op but create on a bad head, or an empty or length query on any node
        hd = $urandom_range(0, 255);
        o = (hd >= NODES) ? op_t'($urandom_range(1, 15)) :
            (($urandom_range(0, 1) == 0) ? OP_EMPTY : OP_LENGTH);
        pos = $urandom_range(0, 255);
      end else begin
        hd = live_heads[$urandom_range(0, live_heads.size() - 1)];
        len = list_len(hd);
        pos = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, len + 2);
        case ($urandom_range(0, 19))
          0:             o = (live_heads.size() > 3) ? OP_DESTROY : OP_LENGTH;
          1:             o = OP_CLEAR;
          2:             o = OP_EMPTY;
          3:             o = OP_LENGTH;
          4, 5:          o = OP_GET;
          6:             o = OP_LOCATE;
          7:             o = OP_NEXT;
          8:             o = OP_PRIOR;
          9, 10, 11:     o = OP_DELETE;
          default:       o = OP_INSERT;
        endcase
        if (o == OP_DESTROY) drop_head(hd);
      end
      send_req(o, hd, pos, v);
    end
  endtask

  // destroying the free head closes the free list on itself; walks must give up
  task automatic test_cyclic();
    int fp;
    wait_drained();
    fp = free_ptr;
    if (fp < NODES) begin
      send_req(OP_DESTROY, fp, 0, 0);
      send_req(OP_DESTROY, fp, 0, 0);
      send_req(OP_CLEAR, fp, 0, 0);
      send_req(OP_LENGTH, fp, 0, 0);
    end
  endtask

  initial begin
    int drain;
    for (int i = 0; i < NODES; i++) begin
      link_mem[i] = (i + 1 < NODES) ? i + 1 : NIL;
      data_mem[i] = 32'd0;
      written[i] = 1'b0;
    end
    free_ptr = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_exhaust();
    test_random(755);
    calm = 1'b0;
    test_cyclic();
    calm = 1'b1;
    test_random(30);
    in_valid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    drain = 0;
    while (drain < 2 * NODES + 20) begin
      @(posedge clk);
      drain++;
    end
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
